@@ src/lmbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local map box recenter package
// Shared widths, register indexes, reset values, the link between the move
// distance unit and the box datapath, and the saturation helper.
// ----------------------------------------------------------------------------
package lmbr_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned CubeW   = 24;
  localparam int unsigned RangeW  = 24;
  localparam int unsigned FactorW = 10;
  localparam int unsigned ThrW    = 26;
  localparam int unsigned MovW    = 28;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [1:0] RegCube   = 2'd0;
  localparam logic [1:0] RegRange  = 2'd1;
  localparam logic [1:0] RegFactor = 2'd2;

  localparam logic [CubeW-1:0]   CubeReset   = 24'd1536000;
  localparam logic [RangeW-1:0]  RangeReset  = 24'd204800;
  localparam logic [FactorW-1:0] FactorReset = 10'd384;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic                   busy;
    logic [ThrW-1:0]        thr;
    logic signed [MovW-1:0] mov;
  } mov_cfg_t;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi_lim;
    logic signed [PosW+1:0] lo_lim;
    hi_lim = 34'sd2147483647;
    lo_lim = -34'sd2147483648;
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end else begin
      return v[PosW-1:0];
    end
  endfunction

endpackage

@@ src/lmbr_mov_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move distance calculator
// Derives the move threshold and the move distance from the configuration
// registers after reset and after every register write. The divide by ten
// is a reciprocal multiply on a biased dividend, and the derivation steps
// through the multiply, threshold, dividend, reciprocal and final states.
// ----------------------------------------------------------------------------
module lmbr_mov_calc
  import lmbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CubeW-1:0]   cube_i,
  input  logic [RangeW-1:0]  range_i,
  input  logic [FactorW-1:0] factor_i,
  output mov_cfg_t           mov_cfg_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StThr  = 3'd2;
  localparam logic [2:0] StDvd  = 3'd3;
  localparam logic [2:0] StRcp  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  localparam int unsigned DivW     = 34;
  localparam int unsigned DvdW     = 30;
  localparam int unsigned QuotW    = MovW - 1;
  localparam int unsigned RcpW     = DvdW + 32;
  localparam int unsigned RcpShift = 35;
  localparam logic signed [DvdW:0]   DivBias  = 31'sd671088640;
  localparam logic signed [MovW-1:0] QBias    = 28'sd67108864;
  localparam logic [31:0]            RecipTen = 32'hCCCC_CCCD;

  logic [2:0]                 state_q, state_d;
  logic [DivW-1:0]            prod_q;
  logic signed [DivW:0]       prod_b_q;
  logic [ThrW-1:0]            thr_q;
  logic signed [MovW-2:0]     b_q;
  logic [DvdW-1:0]            dvd_q;
  logic [QuotW-1:0]           quot_q;
  logic signed [MovW-1:0]     mov_q;

  logic signed [FactorW:0]    factor_s;
  logic signed [MovW-1:0]     diff;
  logic signed [DvdW:0]       nine_x;
  logic signed [DvdW:0]       biased;
  logic [RcpW-1:0]            rcp;
  logic signed [MovW-1:0]     a_val;
  logic signed [MovW-1:0]     b_ext;

  always_comb begin
    factor_s = $signed({1'b0, factor_i}) - 11'sd256;
    diff     = $signed({5'b0, cube_i[CubeW-1:1]}) - $signed({2'b0, thr_q});
    nine_x   = $signed({{(DvdW+1-MovW){diff[MovW-1]}}, diff}) * 31'sd9;
    biased   = nine_x + DivBias;
    rcp      = RcpW'(dvd_q) * RcpW'(RecipTen);
    a_val    = $signed({1'b0, quot_q}) - QBias;
    b_ext    = {b_q[MovW-2], b_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: state_d = StIdle;
      StMul:  state_d = StThr;
      StThr:  state_d = StDvd;
      StDvd:  state_d = StRcp;
      StRcp:  state_d = StFin;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (start_i) begin
      state_d = StMul;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StMul;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StMul: begin
        prod_q   <= {10'b0, range_i} * {24'b0, factor_i};
        prod_b_q <= $signed({11'b0, range_i}) * $signed({{24{factor_s[FactorW]}}, factor_s});
      end
      StThr: begin
        thr_q <= prod_q[DivW-1:8];
        b_q   <= prod_b_q[DivW:8];
      end
      StDvd: begin
        dvd_q <= biased[DvdW-1:0];
      end
      StRcp: begin
        quot_q <= rcp[RcpW-1:RcpShift];
      end
      StFin: begin
        mov_q <= (a_val > b_ext) ? a_val : b_ext;
      end
      default: begin
      end
    endcase
  end

  assign mov_cfg_o.busy = (state_q != StIdle);
  assign mov_cfg_o.thr  = thr_q;
  assign mov_cfg_o.mov  = mov_q;

endmodule

@@ src/lmbr_box_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box update datapath
// Registers one position beat, centres the box on the first valid pose, then tests every axis
// against the box faces, moves the box and parks up to three removal boxes that leave one per beat.
// ----------------------------------------------------------------------------
module lmbr_box_update
  import lmbr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mov_cfg_t               mov_cfg_i,
  input  logic [CubeW-1:0]       cube_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   pose_valid_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             axis_o,
  output logic                   toward_high_o,
  output logic signed [PosW-1:0] rm_min_x_o,
  output logic signed [PosW-1:0] rm_min_y_o,
  output logic signed [PosW-1:0] rm_min_z_o,
  output logic signed [PosW-1:0] rm_max_x_o,
  output logic signed [PosW-1:0] rm_max_y_o,
  output logic signed [PosW-1:0] rm_max_z_o,
  output logic                   last_box_o
);

  localparam int unsigned WideW = PosW + 2;

  logic                   in_vld_q;
  logic                   pose_q;
  logic signed [PosW-1:0] pos_q [3];
  logic                   ready_q;
  logic signed [PosW-1:0] lo_q [3];
  logic signed [PosW-1:0] hi_q [3];
  logic [2:0]             pend_q, pend_d;
  logic [2:0]             dir_q;
  logic signed [PosW-1:0] old_lo_q [3];
  logic signed [PosW-1:0] old_hi_q [3];
  logic signed [PosW-1:0] rmv_q [3];

  logic                   accept;
  logic                   fire;
  logic                   drain;
  logic                   out_take;
  logic [1:0]             sel;
  logic [2:0]             hit;
  logic [2:0]             dir;
  logic signed [PosW-1:0] new_lo [3];
  logic signed [PosW-1:0] new_hi [3];
  logic signed [PosW-1:0] init_lo [3];
  logic signed [PosW-1:0] init_hi [3];
  logic signed [WideW-1:0] half_w;
  logic signed [WideW-1:0] rest_w;
  logic signed [WideW-1:0] mov_w;
  logic [WideW-1:0]        thr_w;
  logic signed [PosW-1:0]  rm_min [3];
  logic signed [PosW-1:0]  rm_max [3];

  always_comb begin
    half_w = $signed({11'b0, cube_i[CubeW-1:1]});
    rest_w = $signed({10'b0, cube_i}) - half_w;
    mov_w  = $signed({{(WideW-MovW){mov_cfg_i.mov[MovW-1]}}, mov_cfg_i.mov});
    thr_w  = {8'b0, mov_cfg_i.thr};
    for (int i = 0; i < 3; i++) begin
      logic signed [WideW-1:0] p_w;
      logic signed [WideW-1:0] l_w;
      logic signed [WideW-1:0] h_w;
      logic signed [WideW-1:0] dlo;
      logic signed [WideW-1:0] dhi;
      logic [WideW-1:0]        mlo;
      logic [WideW-1:0]        mhi;
      p_w = {{2{pos_q[i][PosW-1]}}, pos_q[i]};
      l_w = {{2{lo_q[i][PosW-1]}}, lo_q[i]};
      h_w = {{2{hi_q[i][PosW-1]}}, hi_q[i]};
      dlo = p_w - l_w;
      dhi = p_w - h_w;
      mlo = (dlo < 0) ? WideW'(-dlo) : WideW'(dlo);
      mhi = (dhi < 0) ? WideW'(-dhi) : WideW'(dhi);
      init_lo[i] = sat32(p_w - half_w);
      init_hi[i] = sat32(p_w + rest_w);
      hit[i] = 1'b1;
      dir[i] = 1'b0;
      new_lo[i] = lo_q[i];
      new_hi[i] = hi_q[i];
      if (mlo <= thr_w) begin
        new_lo[i] = sat32(l_w - mov_w);
        new_hi[i] = sat32(h_w - mov_w);
      end else if (mhi <= thr_w) begin
        dir[i] = 1'b1;
        new_lo[i] = sat32(l_w + mov_w);
        new_hi[i] = sat32(h_w + mov_w);
      end else begin
        hit[i] = 1'b0;
      end
    end
  end

  always_comb begin
    if (pend_q[0]) begin
      sel = AxisX;
    end else if (pend_q[1]) begin
      sel = AxisY;
    end else begin
      sel = AxisZ;
    end
    for (int i = 0; i < 3; i++) begin
      rm_min[i] = (sel == 2'(i) && !dir_q[i]) ? rmv_q[i] : old_lo_q[i];
      rm_max[i] = (sel == 2'(i) && dir_q[i]) ? rmv_q[i] : old_hi_q[i];
    end
  end

  assign out_valid_o   = |pend_q;
  assign axis_o        = sel;
  assign toward_high_o = dir_q[sel];
  assign last_box_o    = (sel == AxisZ) || (sel == AxisY && !pend_q[2]) ||
                         (sel == AxisX && pend_q[2:1] == 2'b00);
  assign rm_min_x_o    = rm_min[0];
  assign rm_min_y_o    = rm_min[1];
  assign rm_min_z_o    = rm_min[2];
  assign rm_max_x_o    = rm_max[0];
  assign rm_max_y_o    = rm_max[1];
  assign rm_max_z_o    = rm_max[2];

  assign out_take   = out_valid_o && !out_stall_i;
  assign drain      = out_take && last_box_o;
  assign fire       = in_vld_q && ((pend_q == 3'b000) || drain);
  assign in_stall_o = mov_cfg_i.busy || (in_vld_q && !fire);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pend_d = pend_q;
    if (out_take) begin
      pend_d[sel] = 1'b0;
    end
    if (fire && pose_q && ready_q) begin
      pend_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      ready_q  <= 1'b0;
      pend_q   <= 3'b000;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire && pose_q) begin
        ready_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (fire && pose_q) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= ready_q ? new_lo[i] : init_lo[i];
        hi_q[i] <= ready_q ? new_hi[i] : init_hi[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pose_q   <= pose_valid_i;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
    end
    if (fire && pose_q && ready_q) begin
      dir_q <= dir;
      for (int i = 0; i < 3; i++) begin
        old_lo_q[i] <= lo_q[i];
        old_hi_q[i] <= hi_q[i];
        rmv_q[i]    <= dir[i] ? new_lo[i] : new_hi[i];
      end
    end
  end

endmodule

@@ src/local_map_box_recenter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local map box recenter unit
// Keeps a sliding local map cube around the sensor position and reports the
// strips that fall out of the cube each time it shifts.
// ----------------------------------------------------------------------------
// A position beat is registered and processed once no removal boxes are
// waiting, so one position enters per cycle while none are waiting and the
// move distance unit is idle. A position that moves the box on n axes yields
// n removal beats, at most three, one per cycle while out_stall_i is low, and
// the next position is processed in the cycle its last removal beat leaves.
// After reset and after each register write the move distance unit derives
// the threshold and move distance, dividing by ten with a reciprocal
// multiply, and in_stall_o stays high while it is busy.
// ----------------------------------------------------------------------------
module local_map_box_recenter_unit
  import lmbr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [DataW-1:0]       pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   pose_valid_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             axis_o,
  output logic                   toward_high_o,
  output logic signed [PosW-1:0] rm_min_x_o,
  output logic signed [PosW-1:0] rm_min_y_o,
  output logic signed [PosW-1:0] rm_min_z_o,
  output logic signed [PosW-1:0] rm_max_x_o,
  output logic signed [PosW-1:0] rm_max_y_o,
  output logic signed [PosW-1:0] rm_max_z_o,
  output logic                   last_box_o
);

  logic [CubeW-1:0]   cube_q;
  logic [RangeW-1:0]  range_q;
  logic [FactorW-1:0] factor_q;
  logic               wr_en;
  mov_cfg_t           mov_cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_q   <= CubeReset;
      range_q  <= RangeReset;
      factor_q <= FactorReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegCube:   cube_q   <= pwdata[CubeW-1:0];
        RegRange:  range_q  <= pwdata[RangeW-1:0];
        RegFactor: factor_q <= pwdata[FactorW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCube:   prdata = {8'b0, cube_q};
      RegRange:  prdata = {8'b0, range_q};
      RegFactor: prdata = {22'b0, factor_q};
      default:   prdata = '0;
    endcase
  end

  lmbr_mov_calc u_mov_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (wr_en),
    .cube_i    (cube_q),
    .range_i   (range_q),
    .factor_i  (factor_q),
    .mov_cfg_o (mov_cfg)
  );

  lmbr_box_update u_box_update (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mov_cfg_i     (mov_cfg),
    .cube_i        (cube_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pose_valid_i  (pose_valid_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axis_o        (axis_o),
    .toward_high_o (toward_high_o),
    .rm_min_x_o    (rm_min_x_o),
    .rm_min_y_o    (rm_min_y_o),
    .rm_min_z_o    (rm_min_z_o),
    .rm_max_x_o    (rm_max_x_o),
    .rm_max_y_o    (rm_max_y_o),
    .rm_max_z_o    (rm_max_z_o),
    .last_box_o    (last_box_o)
  );

endmodule
